// ===== src/kle_pkg.sv =====
`timescale 1ns / 1ps

package kle_pkg;

  localparam int ROW_CELLS = 16;
  localparam int LINE_LEN_DEF = 16;
  localparam int COL_W = $clog2(ROW_CELLS);

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [15:0] EVT_KEY = 16'd1;
  localparam logic [1:0] KVAL_PRESS = 2'd1;

  localparam logic [15:0] KEY_ESC = 16'd1;
  localparam logic [15:0] KEY_BKSP = 16'd14;
  localparam logic [15:0] KEY_TAB = 16'd15;
  localparam logic [15:0] KEY_ENTER = 16'd28;
  localparam logic [15:0] KEY_UP = 16'd103;
  localparam logic [15:0] KEY_RIGHT = 16'd106;
  localparam logic [15:0] KEY_DOWN = 16'd108;
  localparam logic [15:0] KEYMAP_SIZE = 16'd64;

  typedef struct packed {
    logic        opcode;
    logic [15:0] event_type;
    logic [15:0] key_code;
    logic [1:0]  key_value;
  } kle_in_t;

  typedef struct packed {
    logic             row;
    logic [COL_W-1:0] column;
    logic [7:0]       character;
    logic             display_on;
    logic             last;
  } kle_out_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_HOLD,
    ACT_PUT,
    ACT_TAB,
    ACT_BKSP,
    ACT_FWD,
    ACT_BACK,
    ACT_ENTER,
    ACT_ESC,
    ACT_TOGGLE
  } kle_act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ROW0,
    ST_ROW1
  } kle_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
    logic row;
  } kle_cmd_t;

  typedef struct packed {
    logic ignore;
    logic two_rows;
    logic col_end;
  } kle_sts_t;

  function automatic logic [7:0] key_char(input logic [5:0] code);
    logic [7:0] ch;
    unique case (code)
      6'd2:  ch = "1";
      6'd3:  ch = "2";
      6'd4:  ch = "3";
      6'd5:  ch = "4";
      6'd6:  ch = "5";
      6'd7:  ch = "6";
      6'd8:  ch = "7";
      6'd9:  ch = "8";
      6'd10: ch = "9";
      6'd11: ch = "0";
      6'd12: ch = "-";
      6'd13: ch = "=";
      6'd16: ch = "q";
      6'd17: ch = "w";
      6'd18: ch = "e";
      6'd19: ch = "r";
      6'd20: ch = "t";
      6'd21: ch = "y";
      6'd22: ch = "u";
      6'd23: ch = "i";
      6'd24: ch = "o";
      6'd25: ch = "p";
      6'd26: ch = "[";
      6'd27: ch = "]";
      6'd30: ch = "a";
      6'd31: ch = "s";
      6'd32: ch = "d";
      6'd33: ch = "f";
      6'd34: ch = "g";
      6'd35: ch = "h";
      6'd36: ch = "j";
      6'd37: ch = "k";
      6'd38: ch = "l";
      6'd44: ch = "z";
      6'd45: ch = "x";
      6'd46: ch = "c";
      6'd47: ch = "v";
      6'd48: ch = "b";
      6'd49: ch = "n";
      6'd50: ch = "m";
      6'd51: ch = ",";
      6'd52: ch = ".";
      6'd53: ch = "/";
      6'd57: ch = " ";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/kle_ctrl.sv =====
`timescale 1ns / 1ps

module kle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  kle_pkg::kle_sts_t sts,
  output kle_pkg::kle_cmd_t cmd,
  output logic              busy
);
  import kle_pkg::*;

  kle_state_t state_r;
  kle_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.ignore) begin
          state_nxt = ST_IDLE;
        end else if (sts.two_rows) begin
          state_nxt = ST_ROW0;
        end else begin
          state_nxt = ST_ROW1;
        end
      end
      ST_ROW0: begin
        if (sts.col_end) begin
          state_nxt = ST_ROW1;
        end
      end
      ST_ROW1: begin
        if (sts.col_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_ROW0: begin
        cmd.emit = 1'b1;
      end
      ST_ROW1: begin
        cmd.emit = 1'b1;
        cmd.row = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

// ===== src/kle_dpath.sv =====
`timescale 1ns / 1ps

module kle_dpath #(
  parameter int LINE_LEN = kle_pkg::LINE_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kle_pkg::kle_in_t  in_data,
  input  kle_pkg::kle_cmd_t cmd,
  output kle_pkg::kle_sts_t sts,
  output logic              out_valid,
  output kle_pkg::kle_out_t out_data
);
  import kle_pkg::*;

  localparam int CW = $clog2(LINE_LEN + 1);
  localparam int PW = CW + 3;

  kle_in_t          item_r;
  logic [CW-1:0]    cur_r;
  logic [CW-1:0]    cur_nxt;
  logic             chat_r;
  logic             chat_nxt;
  logic [7:0]       line_r [ROW_CELLS];
  logic [7:0]       line_nxt [ROW_CELLS];
  logic [7:0]       top_r [ROW_CELLS];
  logic [7:0]       top_nxt [ROW_CELLS];
  logic [COL_W-1:0] col_r;
  logic             out_valid_r;
  kle_out_t         out_r;

  kle_act_t         act;
  logic [7:0]       map_ch;
  logic [CW-1:0]    wr_base;
  logic [2:0]       wr_n;
  logic [7:0]       wr_ch;
  logic [CW-1:0]    cur_back;
  logic [CW:0]      tab_end;
  logic [PW-1:0]    wr_lo;
  logic [PW-1:0]    wr_hi;

  always_comb begin
    act = ACT_NONE;
    map_ch = key_char(item_r.key_code[5:0]);
    if (item_r.opcode) begin
      act = ACT_TOGGLE;
    end else if (chat_r && item_r.event_type == EVT_KEY && item_r.key_value == KVAL_PRESS) begin
      unique case (item_r.key_code) inside
        KEY_ESC:          act = ACT_ESC;
        KEY_BKSP:         act = ACT_BKSP;
        KEY_TAB:          act = ACT_TAB;
        KEY_ENTER:        act = ACT_ENTER;
        KEY_UP, KEY_RIGHT: act = ACT_FWD;
        KEY_DOWN:         act = ACT_BACK;
        default: begin
          act = (item_r.key_code < KEYMAP_SIZE && map_ch != 8'h00) ? ACT_PUT : ACT_HOLD;
        end
      endcase
    end
  end

  assign sts.ignore = (act == ACT_NONE);
  assign sts.two_rows = (act == ACT_ENTER) || (act == ACT_TOGGLE);
  assign sts.col_end = (col_r == COL_W'(ROW_CELLS - 1));

  assign cur_back = (cur_r == '0) ? '0 : cur_r - CW'(1);
  assign tab_end = {1'b0, cur_r} + (CW + 1)'(4);

  always_comb begin
    wr_base = cur_r;
    wr_n = 3'd0;
    wr_ch = SPACE_CHAR;
    cur_nxt = cur_r;
    chat_nxt = chat_r;
    for (int i = 0; i < ROW_CELLS; i++) begin
      line_nxt[i] = line_r[i];
      top_nxt[i] = top_r[i];
    end
    if (cmd.exec) begin
      case (act)
        ACT_PUT: begin
          wr_n = 3'd1;
          wr_ch = map_ch;
          if (cur_r < CW'(LINE_LEN)) begin
            cur_nxt = cur_r + CW'(1);
          end
        end
        ACT_TAB: begin
          wr_n = 3'd4;
          cur_nxt = (tab_end > (CW + 1)'(LINE_LEN)) ? CW'(LINE_LEN) : tab_end[CW-1:0];
        end
        ACT_BKSP: begin
          wr_base = cur_back;
          wr_n = 3'd1;
          cur_nxt = cur_back;
        end
        ACT_FWD: begin
          if (cur_r < CW'(LINE_LEN)) begin
            cur_nxt = cur_r + CW'(1);
          end
        end
        ACT_BACK: begin
          cur_nxt = cur_back;
        end
        ACT_ENTER: begin
          cur_nxt = '0;
          for (int i = 0; i < ROW_CELLS; i++) begin
            top_nxt[i] = line_r[i];
            line_nxt[i] = SPACE_CHAR;
          end
        end
        ACT_ESC: begin
          cur_nxt = '0;
          chat_nxt = 1'b0;
          for (int i = 0; i < ROW_CELLS; i++) begin
            line_nxt[i] = SPACE_CHAR;
          end
        end
        ACT_TOGGLE: begin
          chat_nxt = ~chat_r;
        end
        default: begin
          cur_nxt = cur_r;
        end
      endcase
    end
    wr_lo = {3'b000, wr_base};
    wr_hi = wr_lo + PW'(wr_n);
    for (int i = 0; i < ROW_CELLS; i++) begin
      if (PW'(i) >= wr_lo && PW'(i) < wr_hi && PW'(i) < PW'(LINE_LEN)) begin
        line_nxt[i] = wr_ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      chat_r <= 1'b0;
      col_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ROW_CELLS; i++) begin
        line_r[i] <= SPACE_CHAR;
        top_r[i] <= SPACE_CHAR;
      end
    end else begin
      cur_r <= cur_nxt;
      chat_r <= chat_nxt;
      out_valid_r <= cmd.emit;
      for (int i = 0; i < ROW_CELLS; i++) begin
        line_r[i] <= line_nxt[i];
        top_r[i] <= top_nxt[i];
      end
      if (cmd.exec) begin
        col_r <= '0;
      end else if (cmd.emit) begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.row <= cmd.row;
      out_r.column <= col_r;
      out_r.character <= cmd.row ? line_r[col_r] : top_r[col_r];
      out_r.display_on <= chat_r;
      out_r.last <= cmd.row && sts.col_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

// ===== src/keyboard_line_editor.sv =====
`timescale 1ns / 1ps

// Line editor for keyboard events with a two-row, sixteen-cell text display.
// A request is taken on in_data at a rising edge where start is high and busy
// is low; busy stays high until the request's last result has been issued.
// Results leave one cell per cycle on out_data, each marked by out_valid for a
// single cycle; out_data.last flags the final cell of a request. The receiver
// cannot hold results off, so out_valid is simply a strobe.
// Sequence: the accepting edge registers the request and enters the execute
// state, which applies the edit; the controller then walks the display rows,
// and each cell is registered before it appears on out_data. A request emits
// one row, or both rows (Enter, toggle); an ignored event emits none and the
// controller returns to idle from the execute state. A new request is taken
// only while busy is low. The column counter reads out one display cell per cycle.
// Reset (synchronous, active low) clears the edit line and the committed row
// to spaces, returns the cursor to column 0 and turns chat mode off.
module keyboard_line_editor #(
  parameter int LINE_LEN = kle_pkg::LINE_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  kle_pkg::kle_in_t  in_data,
  output logic              out_valid,
  output kle_pkg::kle_out_t out_data
);
  import kle_pkg::*;

  kle_cmd_t cmd;
  kle_sts_t sts;

  kle_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  kle_dpath #(
    .LINE_LEN (LINE_LEN)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after a request was accepted");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("result issued after the last result of a request");

  a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && out_valid |-> out_data.last)
    else $error("controller idle while a request still has results pending");

  a_row_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid)
    else $error("gap inside a row burst");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import kle_pkg::*;

  localparam int LINE_LEN = LINE_LEN_DEF;
  localparam int SHOWN_CELLS = (LINE_LEN < ROW_CELLS) ? LINE_LEN : ROW_CELLS;
  localparam logic [15:0] KEY_SPACE_CODE = 16'd57;
  localparam int RANDOM_EVENTS = 450;
  localparam int QUIET_LIMIT = 600;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    kle_in_t req;
    bit      drain;
  } key_event_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  kle_in_t  in_data = '0;
  logic     out_valid;
  kle_out_t out_data;

  key_event_t key_events[$];
  kle_out_t   due_cells[$];

  logic [7:0] line_cells [LINE_LEN];
  logic [7:0] top_cells [ROW_CELLS];
  logic [7:0] bottom_cells [ROW_CELLS];
  int         cursor;
  bit         chat_on;

  bit         gen_chat;
  int         n_events;
  int         n_accepted;
  int         mismatches;
  int         idle_left;
  bit         no_idle;
  int         quiet_cycles;
  key_event_t head;

  keyboard_line_editor #(.LINE_LEN(LINE_LEN)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] keycap(input logic [15:0] code);
    string digits;
    string top_keys;
    string home_keys;
    string low_keys;
    int    c;
    logic [7:0] ch;
    digits = "1234567890-=";
    top_keys = "qwertyuiop[]";
    home_keys = "asdfghjkl";
    low_keys = "zxcvbnm,./";
    c = int'(code);
    ch = 8'h00;
    if (c >= 2 && c <= 13) ch = digits[c - 2];
    else if (c >= 16 && c <= 27) ch = top_keys[c - 16];
    else if (c >= 30 && c <= 38) ch = home_keys[c - 30];
    else if (c >= 44 && c <= 53) ch = low_keys[c - 44];
    else if (code == KEY_SPACE_CODE) ch = SPACE_CHAR;
    return ch;
  endfunction

  task automatic clear_line();
    for (int i = 0; i < LINE_LEN; i++) line_cells[i] = SPACE_CHAR;
    cursor = 0;
  endtask

  task automatic put_cell(input logic [7:0] ch);
    if (cursor < LINE_LEN) begin
      line_cells[cursor] = ch;
      cursor++;
    end
  endtask

  task automatic cursor_back();
    if (cursor > 0) cursor--;
  endtask

  task automatic show_line(output logic [7:0] cells [ROW_CELLS]);
    for (int i = 0; i < ROW_CELLS; i++) cells[i] = (i < SHOWN_CELLS) ? line_cells[i] : SPACE_CHAR;
  endtask

  task automatic init_model();
    clear_line();
    for (int i = 0; i < ROW_CELLS; i++) begin
      top_cells[i] = SPACE_CHAR;
      bottom_cells[i] = SPACE_CHAR;
    end
    chat_on = 1'b0;
  endtask

  task automatic emit_row(ref kle_out_t batch[$], input logic r);
    kle_out_t res;
    for (int i = 0; i < ROW_CELLS; i++) begin
      res.row = r;
      res.column = i[COL_W-1:0];
      res.character = r ? bottom_cells[i] : top_cells[i];
      res.display_on = chat_on;
      res.last = 1'b0;
      batch.push_back(res);
    end
  endtask

  task automatic predict_display(input kle_in_t req);
    kle_out_t   batch[$];
    logic [7:0] ch;
    if (req.opcode) begin
      chat_on = !chat_on;
      emit_row(batch, 1'b0);
      emit_row(batch, 1'b1);
    end else begin
      if (!chat_on || req.event_type != EVT_KEY || req.key_value != KVAL_PRESS) return;
      case (req.key_code)
        KEY_ESC: begin
          clear_line();
          chat_on = 1'b0;
        end
        KEY_BKSP: begin
          cursor_back();
          put_cell(SPACE_CHAR);
          cursor_back();
        end
        KEY_TAB: begin
          repeat (4) put_cell(SPACE_CHAR);
        end
        KEY_ENTER: begin
          show_line(top_cells);
          clear_line();
          emit_row(batch, 1'b0);
        end
        KEY_UP, KEY_RIGHT: begin
          if (cursor < LINE_LEN) cursor++;
        end
        KEY_DOWN: begin
          cursor_back();
        end
        default: begin
          ch = keycap(req.key_code);
          if (ch != 8'h00) put_cell(ch);
        end
      endcase
      show_line(bottom_cells);
      emit_row(batch, 1'b1);
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) due_cells.push_back(batch[i]);
  endtask

  task automatic add_event(input kle_in_t req, input bit drain = 1'b0);
    key_event_t ev;
    ev.req = req;
    ev.drain = drain;
    key_events.push_back(ev);
    n_events++;
    if (req.opcode) gen_chat = !gen_chat;
    else if (gen_chat && req.event_type == EVT_KEY && req.key_value == KVAL_PRESS
             && req.key_code == KEY_ESC) gen_chat = 1'b0;
  endtask

  function automatic kle_in_t press(input logic [15:0] code);
    kle_in_t req;
    req.opcode = 1'b0;
    req.event_type = EVT_KEY;
    req.key_code = code;
    req.key_value = KVAL_PRESS;
    return req;
  endfunction

  function automatic kle_in_t key_event(input logic [15:0] etype, input logic [15:0] code,
                                        input logic [1:0] kval);
    kle_in_t req;
    req.opcode = 1'b0;
    req.event_type = etype;
    req.key_code = code;
    req.key_value = kval;
    return req;
  endfunction

  function automatic kle_in_t toggle_click();
    kle_in_t req;
    req.opcode = 1'b1;
    req.event_type = 16'($urandom_range(0, 65535));
    req.key_code = 16'($urandom_range(0, 65535));
    req.key_value = 2'($urandom_range(0, 2));
    return req;
  endfunction

  function automatic logic [15:0] mapped_code();
    logic [15:0] code;
    do code = 16'($urandom_range(0, 63)); while (keycap(code) == 8'h00);
    return code;
  endfunction

  task automatic add_edit_key();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) add_event(press(mapped_code()));
    else if (pick < 62) add_event(press(KEY_TAB));
    else if (pick < 70) add_event(press(KEY_BKSP));
    else if (pick < 76) add_event(press($urandom_range(0, 1) ? KEY_UP : KEY_RIGHT));
    else if (pick < 82) add_event(press(KEY_DOWN));
    else if (pick < 86) add_event(press(16'($urandom_range(0, 65535))));
    else if (pick < 95) add_event(key_event(16'($urandom_range(0, 65535)),
                                            16'($urandom_range(0, 65535)),
                                            2'($urandom_range(0, 2))));
    else if (pick < 97) add_event(key_event(EVT_KEY, mapped_code(),
                                            $urandom_range(0, 1) ? 2'd0 : 2'd2));
    else if (pick < 99) add_event(press(KEY_ENTER));
    else add_event(toggle_click());
  endtask

  task automatic build_events();
    int pick;
    add_event(toggle_click());
    add_event(press(KEY_BKSP));
    add_event(press(16'd30));
    add_event(press(16'd2));
    add_event(press(16'd13));
    add_event(press(16'd53));
    add_event(press(KEY_SPACE_CODE));
    add_event(press(16'd0));
    add_event(press(16'hFFFF));
    add_event(key_event(16'd0, 16'd16, KVAL_PRESS));
    add_event(key_event(16'hFFFF, 16'hFFFF, KVAL_PRESS));
    add_event(key_event(EVT_KEY, 16'd16, 2'd0));
    add_event(key_event(EVT_KEY, 16'd16, 2'd2));
    repeat (3) add_event(press(KEY_TAB));
    add_event(press(16'd16));
    add_event(press(KEY_TAB));
    add_event(press(KEY_UP));
    add_event(press(KEY_DOWN));
    add_event(press(KEY_RIGHT));
    add_event(press(KEY_ENTER));
    add_event(press(KEY_ESC));
    add_event(press(16'd38));
    add_event('{opcode: 1'b1, event_type: 16'hFFFF, key_code: 16'hFFFF, key_value: 2'd2}, 1'b1);
    while (n_events < RANDOM_EVENTS) begin
      if (!gen_chat) add_event(toggle_click(), $urandom_range(0, 19) == 0);
      repeat ($urandom_range(1, 24)) add_edit_key();
      pick = $urandom_range(0, 3);
      if (pick < 2) add_event(press(KEY_ENTER));
      else if (pick == 2) add_event(press(KEY_ESC));
      else if (gen_chat) add_event(toggle_click());
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        predict_display(in_data);
        n_accepted++;
        idle_left = no_idle ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
      end
      if (!(start && busy)) begin
        if (idle_left > 0 || key_events.size() == 0
            || (key_events[0].drain && due_cells.size() != 0)) begin
          start <= 1'b0;
          if (idle_left > 0 && !busy) idle_left--;
        end else begin
          head = key_events.pop_front();
          in_data <= head.req;
          start <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    kle_out_t want;
    if (rst_n && out_valid) begin
      if (due_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: row %0d col %0d char %h on %b last %b",
                   out_data.row, out_data.column, out_data.character,
                   out_data.display_on, out_data.last);
      end else begin
        want = due_cells.pop_front();
        if (want.row != out_data.row || want.column != out_data.column
            || want.character != out_data.character
            || want.display_on != out_data.display_on || want.last != out_data.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected row %0d col %0d char %h on %b last %b,",
                     want.row, want.column, want.character, want.display_on, want.last,
                     " got row %0d col %0d char %h on %b last %b",
                     out_data.row, out_data.column, out_data.character,
                     out_data.display_on, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no request or result for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    init_model();
    build_events();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (n_accepted < n_events || due_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_cells.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== keyboard_line_editor.f =====
src/kle_pkg.sv
src/kle_ctrl.sv
src/kle_dpath.sv
src/keyboard_line_editor.sv
test/testbench.sv
